// ===== rtl/can_multiframe_reply_aggregator_core_defines.svh =====
// ----------------------------------------------------------------------------
// can_multiframe_reply_aggregator_core_defines
// Assertion macros for the CAN reply aggregator.
// ----------------------------------------------------------------------------
`ifndef CAN_MULTIFRAME_REPLY_AGGREGATOR_CORE_DEFINES_SVH
`define CAN_MULTIFRAME_REPLY_AGGREGATOR_CORE_DEFINES_SVH
`ifndef SYNTH
`define CMRA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CMRA_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CMRA_ASSERT(label, clk, rst, prop, msg)
`define CMRA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/cmra_pkg.sv =====
// ----------------------------------------------------------------------------
// cmra_pkg
// Shared types and constants of the CAN reply aggregator.
// ----------------------------------------------------------------------------
package cmra_pkg;
  localparam int unsigned MaxMessageBytes = 256;
  localparam logic [28:0] ReplyIdReset = 29'd1979;
  localparam logic [7:0] SeqFirst = 8'h10;
  localparam logic [7:0] SeqContBase = 8'h20;
  localparam logic [3:0] SeqMask = 4'hf;
  localparam logic [3:0] FrameBytes = 4'd8;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [28:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
  } frame_t;

  typedef struct packed {
    logic        is_assembled;
    logic [28:0] out_id;
    logic [3:0]  chunk_len;
    logic [63:0] chunk_data;
    logic [7:0]  message_len;
    logic        last_chunk;
  } result_t;

  // classified request from front to back
  typedef struct packed {
    logic        pass;
    logic [28:0] id;
    logic [3:0]  start;
    logic [3:0]  len;
    logic [63:0] data;
  } req_t;
endpackage

// ===== rtl/cmra_if.sv =====
// ----------------------------------------------------------------------------
// cmra_frame_if / cmra_result_if / cmra_cfg_if
// Valid/ready channels of the CAN reply aggregator.
// ----------------------------------------------------------------------------
interface cmra_frame_if;
  logic            valid;
  logic            ready;
  logic [28:0]     frame_id;
  logic [3:0]      frame_len;
  logic [63:0]     frame_data;
  modport source (output valid, frame_id, frame_len, frame_data, input ready);
  modport sink (input valid, frame_id, frame_len, frame_data, output ready);
endinterface

interface cmra_result_if;
  logic        valid;
  logic        ready;
  logic        is_assembled;
  logic [28:0] out_id;
  logic [3:0]  chunk_len;
  logic [63:0] chunk_data;
  logic [7:0]  message_len;
  logic        last_chunk;
  modport source (output valid, is_assembled, out_id, chunk_len, chunk_data, message_len,
                  last_chunk, input ready);
  modport sink (input valid, is_assembled, out_id, chunk_len, chunk_data, message_len,
                last_chunk, output ready);
endinterface

interface cmra_cfg_if;
  logic        valid;
  logic        ready;
  logic [28:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/cmra_front.sv =====
// ----------------------------------------------------------------------------
// cmra_front
// Clamps length, checks id and sequence, tracks message header state.
// ----------------------------------------------------------------------------
module cmra_front #(
  parameter int unsigned MAX_MESSAGE_BYTES = cmra_pkg::MaxMessageBytes
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [28:0]          reply_id,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cmra_pkg::frame_t     frame,
  output logic                 req_valid,
  input  logic                 req_ready,
  output cmra_pkg::req_t       req
);
  logic [7:0] expected_sequence, expected_sequence_next;
  logic       active, active_next;
  logic [7:0] declared_length, declared_length_next;
  logic [8:0] collected, collected_next;
  logic [3:0] len;
  logic [7:0] b0;
  logic [3:0] start;
  logic [7:0] decl;
  logic [8:0] base, sum, lim;
  logic       fire;

  assign len = (frame.frame_len > cmra_pkg::FrameBytes) ? cmra_pkg::FrameBytes
                                                        : frame.frame_len;
  assign b0 = frame.frame_data[7:0];
  assign in_ready = req_ready;
  assign fire = in_valid && req_ready;

  assign start = active ? 4'd1 : 4'd2;
  assign decl = active ? declared_length : frame.frame_data[15:8];
  assign base = active ? collected : 9'd0;
  assign lim = ({1'b0, decl} < 9'(MAX_MESSAGE_BYTES)) ? {1'b0, decl}
                                                      : 9'(MAX_MESSAGE_BYTES);
  assign sum = base + {5'd0, len - start};

  always_comb begin
    req = '0;
    req_valid = 1'b0;
    expected_sequence_next = expected_sequence;
    active_next = active;
    declared_length_next = declared_length;
    collected_next = collected;
    req.id = frame.frame_id;
    req.len = len;
    req.data = frame.frame_data;
    priority if (frame.frame_id != reply_id) begin
      req.pass = 1'b1;
      req_valid = in_valid;
    end else if (len == 4'd0 || b0 != expected_sequence || (!active && len < 4'd2)) begin
      expected_sequence_next = cmra_pkg::SeqFirst;
      active_next = 1'b0;
      declared_length_next = '0;
      collected_next = '0;
    end else begin
      req_valid = in_valid;
      req.start = start;
      if (sum >= lim) begin
        expected_sequence_next = cmra_pkg::SeqFirst;
        active_next = 1'b0;
        declared_length_next = '0;
        collected_next = '0;
      end else begin
        active_next = 1'b1;
        declared_length_next = decl;
        collected_next = sum;
        expected_sequence_next = cmra_pkg::SeqContBase
                                 | {4'd0, (expected_sequence[3:0] + 4'd1) & cmra_pkg::SeqMask};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_sequence <= cmra_pkg::SeqFirst;
      active <= 1'b0;
      declared_length <= '0;
      collected <= '0;
    end else if (fire) begin
      expected_sequence <= expected_sequence_next;
      active <= active_next;
      declared_length <= declared_length_next;
      collected <= collected_next;
    end
  end
endmodule

// ===== rtl/cmra_back.sv =====
// ----------------------------------------------------------------------------
// cmra_back
// Stores payload bytes in the buffer and emits results.
// ----------------------------------------------------------------------------
module cmra_back #(
  parameter int unsigned MAX_MESSAGE_BYTES = cmra_pkg::MaxMessageBytes
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [28:0]         reply_id,
  input  logic                req_valid,
  output logic                req_ready,
  input  cmra_pkg::req_t      req,
  output logic                out_valid,
  input  logic                out_ready,
  output cmra_pkg::result_t   out
);
  localparam int unsigned AW = $clog2(MAX_MESSAGE_BYTES);
  localparam int unsigned CW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_WRITE = 4'b0010, S_READ = 4'b0100, S_EMIT = 4'b1000
  } state_t;

  state_t      state;
  logic [7:0]  mem [MAX_MESSAGE_BYTES];
  logic [7:0]  rd_data;
  cmra_pkg::req_t cur;
  logic [3:0]  idx;
  logic [7:0]  declared_length;
  logic [CW-1:0] collected, lim, rd_ptr;
  logic [3:0]  chunk_cnt;
  logic [63:0] chunk_acc;
  logic        rd_pend;
  logic [7:0]  cur_byte;

  assign lim = ({1'b0, declared_length} < CW'(MAX_MESSAGE_BYTES))
               ? CW'(declared_length) : CW'(MAX_MESSAGE_BYTES);
  assign req_ready = (state == S_IDLE) && !out_valid;
  assign cur_byte = cur.data[{idx[2:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (state == S_WRITE && idx < cur.len && collected < lim)
      mem[collected[AW-1:0]] <= cur_byte;
    rd_data <= mem[rd_ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      collected <= '0;
      declared_length <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid && req_ready) begin
            cur <= req;
            idx <= req.start;
            if (req.pass) begin
              out_valid <= 1'b1;
              out.is_assembled <= 1'b0;
              out.out_id <= req.id;
              out.chunk_len <= req.len;
              for (int b = 0; b < 8; b++)
                out.chunk_data[b*8 +: 8] <= (4'(b) < req.len) ? req.data[b*8 +: 8] : 8'd0;
              out.message_len <= {4'd0, req.len};
              out.last_chunk <= 1'b1;
            end else begin
              if (req.start == 4'd2) begin
                declared_length <= req.data[15:8];
                collected <= '0;
              end
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          if (idx < cur.len) begin
            if (collected < lim) collected <= collected + CW'(1);
            idx <= idx + 4'd1;
          end else if (collected >= lim) begin
            rd_ptr <= '0;
            chunk_cnt <= '0;
            chunk_acc <= '0;
            rd_pend <= 1'b0;
            if (collected == '0) begin
              out_valid <= 1'b1;
              out.is_assembled <= 1'b1;
              out.out_id <= reply_id;
              out.chunk_len <= '0;
              out.chunk_data <= '0;
              out.message_len <= declared_length;
              out.last_chunk <= 1'b1;
              collected <= '0;
              state <= S_EMIT;
            end else begin
              state <= S_READ;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_READ: begin
          if (!out_valid || out_ready) begin
            if (rd_pend) begin
              rd_pend <= 1'b0;
              if (chunk_cnt == 4'd7 || rd_ptr == collected) begin
                out_valid <= 1'b1;
                out.is_assembled <= 1'b1;
                out.out_id <= reply_id;
                out.chunk_len <= chunk_cnt + 4'd1;
                out.chunk_data <= chunk_acc | ({56'd0, rd_data} << {chunk_cnt[2:0], 3'b000});
                out.message_len <= declared_length;
                out.last_chunk <= (rd_ptr == collected);
                chunk_cnt <= '0;
                chunk_acc <= '0;
                if (rd_ptr == collected) begin
                  collected <= '0;
                  state <= S_EMIT;
                end
              end else begin
                chunk_acc[{chunk_cnt[2:0], 3'b000} +: 8] <= rd_data;
                chunk_cnt <= chunk_cnt + 4'd1;
              end
            end else begin
              rd_ptr <= rd_ptr + CW'(1);
              rd_pend <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/cmra_queue.sv =====
// ----------------------------------------------------------------------------
// cmra_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module cmra_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  cmra_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output cmra_pkg::req_t out_req
);
  cmra_pkg::req_t q [cmra_pkg::QueueDepth];
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = count < 2'(cmra_pkg::QueueDepth);
  assign out_valid = count != 2'd0;
  assign out_req = q[0];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else count <= count + {1'b0, push} - {1'b0, pop};
    if (pop) q[0] <= push ? in_req : q[1];
    else if (push) q[count[0]] <= in_req;
  end
endmodule

// ===== rtl/can_multiframe_reply_aggregator_core.sv =====
// A passthrough result is registered in the queue, then in the back; message bytes are
// written one per cycle, then read out of the registered buffer one byte at a time, held
// while a result waits, up to 8 bytes to a chunk. The back takes a new request only when
// idle with no result pending: the last one's bytes written, a completed message read out.
// Reset: synchronous; reply_id 1979, expected sequence 0x10, no message active.
// ----------------------------------------------------------------------------
// can_multiframe_reply_aggregator_core
// CAN multi-frame reply reassembly with passthrough of other identifiers.
// ----------------------------------------------------------------------------
`include "can_multiframe_reply_aggregator_core_defines.svh"
module can_multiframe_reply_aggregator_core #(
  parameter int unsigned MAX_MESSAGE_BYTES = cmra_pkg::MaxMessageBytes
) (
  input logic clk,
  input logic rst,
  cmra_frame_if.sink    frame,
  cmra_result_if.source result,
  cmra_cfg_if.sink      cfg
);
  logic [28:0] reply_id;
  cmra_pkg::frame_t f;
  cmra_pkg::req_t fq, qb;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  cmra_pkg::result_t r;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) reply_id <= cmra_pkg::ReplyIdReset;
    else if (cfg.valid) reply_id <= cfg.data;
  end

  assign f = '{frame_id: frame.frame_id, frame_len: frame.frame_len,
               frame_data: frame.frame_data};

  cmra_front #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_front (.clk, .rst, .reply_id,
    .in_valid(frame.valid), .in_ready(frame.ready),
    .frame(f), .req_valid(fq_valid), .req_ready(fq_ready), .req(fq));
  cmra_queue u_queue (.clk, .rst, .in_valid(fq_valid), .in_ready(fq_ready), .in_req(fq),
    .out_valid(qb_valid), .out_ready(qb_ready), .out_req(qb));
  cmra_back #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_back (.clk, .rst, .reply_id,
    .req_valid(qb_valid), .req_ready(qb_ready), .req(qb),
    .out_valid(result.valid), .out_ready(result.ready), .out(r));

  assign result.is_assembled = r.is_assembled;
  assign result.out_id = r.out_id;
  assign result.chunk_len = r.chunk_len;
  assign result.chunk_data = r.chunk_data;
  assign result.message_len = r.message_len;
  assign result.last_chunk = r.last_chunk;

  `CMRA_ASSERT(a_len_max, clk, rst, result.valid |-> result.chunk_len <= 4'd8, "chunk_len over 8")
  `CMRA_ASSERT(a_pass_last, clk, rst,
    (result.valid && !result.is_assembled) |-> result.last_chunk, "pass not last")
  `CMRA_ASSERT_NORST(a_rst_idle, clk, ($past(rst) && !rst) |-> !result.valid, "valid after reset")
endmodule
